// ===== hw/rtl/dpq_pkg.sv =====
// Shared types and constants for the double-ended priority queue.
package dpq_pkg;

   localparam int KEY_W        = 32;
   localparam int ENTRY_W      = 7;
   localparam int REQ_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int DEF_CAPACITY = 64;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT  = 2'd0,
      REQ_DEL_MAX = 2'd1,
      REQ_DEL_MIN = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_code_type;

   // What every cell of the chain does on an update.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [KEY_W-1:0]  key;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/dpq_cell.sv =====
// One storage cell of the sorted key chain.
module dpq_cell (
   input  logic                            clock,
   input  dpq_pkg::cell_ctrl_type          ctrl,
   input  logic                            occupied,
   input  logic                            left_gt,
   input  logic signed [dpq_pkg::KEY_W-1:0] left_key,
   input  logic signed [dpq_pkg::KEY_W-1:0] right_key,
   output logic                            key_gt,
   output logic signed [dpq_pkg::KEY_W-1:0] key
);
   import dpq_pkg::*;

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;

   // This cell holds a key larger than the one being inserted.
   assign key_gt = occupied && (key_ff > ctrl.key);
   assign key    = key_ff;

   always_comb begin
      key_in = key_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (left_gt) begin
               key_in = left_key;
            end else if (key_gt || !occupied) begin
               key_in = ctrl.key;
            end
         end
         CELL_SHIFT: begin
            key_in = right_key;
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== hw/rtl/double_ended_priority_queue.sv =====
// Top level of the double-ended priority queue: a sorted chain of key cells.
//
//   Channel   Direction  Handshake              Word
//   req_      in         req_valid/req_ready    request code and key to insert
//   rsp_      out        rsp_valid/rsp_ready    max, min, entry count, status
//
// An accepted request makes the cell chain insert or drop a key, and the
// result word is registered at the accepting edge, so it shows in the
// cycle after. One request per cycle is sustained while the result side
// keeps taking words; while the single result register is held, req_ready
// stays low. Reset clears the entry count and the result valid flag; key
// cells have no reset and are only read below the entry count.
module double_ended_priority_queue #(
   parameter int CAPACITY = dpq_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dpq_pkg::REQ_W-1:0]           req_type,
   input  logic signed [dpq_pkg::KEY_W-1:0]    req_key_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dpq_pkg::KEY_W-1:0]    rsp_max_key,
   output logic signed [dpq_pkg::KEY_W-1:0]    rsp_min_key,
   output logic [dpq_pkg::ENTRY_W-1:0]         rsp_entry_count,
   output logic [dpq_pkg::STATUS_W-1:0]        rsp_status
);
   import dpq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   // Cell chain: cell 0 holds the smallest key, keys ascend with the index.
   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]     cell_gt;
   logic [CAPACITY-1:0]     occupied;
   logic [CAPACITY-1:0]     is_last;
   cell_ctrl_type           ctrl;

   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic                    accept;
   logic                    empty;
   logic                    full;
   logic                    single;

   logic signed [KEY_W-1:0] max_cur;
   logic signed [KEY_W-1:0] max_second;
   logic signed [KEY_W-1:0] max_in;
   logic signed [KEY_W-1:0] min_in;
   status_code_type         status_in;

   logic                    rsp_valid_ff;
   logic signed [KEY_W-1:0] rsp_max_ff;
   logic signed [KEY_W-1:0] rsp_min_ff;
   logic [CW-1:0]           rsp_count_ff;
   status_code_type         rsp_status_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(CAPACITY));
   assign single    = (count_ff == CW'(1));

   // Occupancy follows from the entry count; the last occupied cell holds
   // the maximum.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_occ
      assign occupied[i] = (CW'(i) < count_ff);
      if (i == CAPACITY - 1) begin : g_end
         assign is_last[i] = occupied[i];
      end else begin : g_mid
         assign is_last[i] = occupied[i] && !occupied[i+1];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    left_gt;
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_gt  = 1'b0;
         assign left_key = '0;
      end else begin : g_left
         assign left_gt  = cell_gt[i-1];
         assign left_key = cell_key[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_right
         assign right_key = cell_key[i+1];
      end

      dpq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied[i]),
         .left_gt   (left_gt),
         .left_key  (left_key),
         .right_key (right_key),
         .key_gt    (cell_gt[i]),
         .key       (cell_key[i])
      );
   end

   // The current maximum and the key just below it, picked by the one-hot
   // last-cell flags.
   always_comb begin
      max_cur    = '0;
      max_second = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (is_last[i]) begin
            max_cur = max_cur | cell_key[i];
         end
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         if (is_last[i+1]) begin
            max_second = max_second | cell_key[i];
         end
      end
   end

   // Request decode: chain command, next count, and the result word taken
   // from the chain as it stands before the update.
   always_comb begin
      ctrl.op   = CELL_HOLD;
      ctrl.key  = req_key_value;
      count_in  = count_ff;
      status_in = ST_DONE;
      max_in    = empty ? '0 : max_cur;
      min_in    = empty ? '0 : cell_key[0];
      case (req_type)
         REQ_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.op  = CELL_INSERT;
               count_in = count_ff + CW'(1);
               max_in   = (empty || req_key_value > max_cur) ? req_key_value : max_cur;
               min_in   = (empty || req_key_value < cell_key[0]) ?
                          req_key_value : cell_key[0];
            end
         end
         REQ_DEL_MAX: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
               max_in   = single ? '0 : max_second;
               min_in   = single ? '0 : cell_key[0];
            end
         end
         REQ_DEL_MIN: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               ctrl.op  = CELL_SHIFT;
               count_in = count_ff - CW'(1);
               max_in   = single ? '0 : max_cur;
               min_in   = single ? '0 : cell_key[1];
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
      if (!accept) begin
         ctrl.op  = CELL_HOLD;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_max_ff    <= max_in;
         rsp_min_ff    <= min_in;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_key     = rsp_max_ff;
   assign rsp_min_key     = rsp_min_ff;
   assign rsp_entry_count = ENTRY_W'(rsp_count_ff);
   assign rsp_status      = rsp_status_ff;

endmodule
